[rtl/deus_pkg.sv]
// Shared types, constants and functions for the dirty entry update scheduler.
package deus_pkg;

   localparam int TableDepth = 32;
   localparam int BatchMax   = 7;
   localparam int IndexWidth = 5;
   localparam int HandleWidth = 24;

   localparam logic [2:0] FuncTick      = 3'd0;
   localparam logic [2:0] FuncCreate    = 3'd1;
   localparam logic [2:0] FuncMark      = 3'd2;
   localparam logic [2:0] FuncVisible   = 3'd3;
   localparam logic [2:0] FuncDelete    = 3'd4;
   localparam logic [2:0] FuncDeleteAll = 3'd5;

   localparam logic [1:0] KindAck    = 2'd0;
   localparam logic [1:0] KindBatch  = 2'd1;
   localparam logic [1:0] KindString = 2'd2;

   localparam logic [1:0] OpAdd    = 2'd0;
   localparam logic [1:0] OpModify = 2'd1;
   localparam logic [1:0] OpDelete = 2'd2;

   // flag bit positions
   localparam int FlagValid = 0;
   localparam int FlagDel   = 1;
   localparam int FlagDirty = 2;
   localparam int FlagDvis  = 3;
   localparam int FlagVis   = 4;
   localparam int FlagStr   = 5;

   typedef logic [5:0] flags_type;

   // datapath commands from the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_FLAGS_CMD,   // apply mark, visibility or delete to the addressed entry
      CMD_DEL_ALL,     // set deleted on the entry at the sweep pointer
      CMD_FIND_FREE,   // test the entry at the sweep pointer for create
      CMD_CREATE,      // write the found entry
      CMD_SCAN,        // batch scan step at the sweep pointer
      CMD_STR_SEND,    // clear dirty on the pending string entry
      CMD_STR_SEARCH,  // search step for the next pending string
      CMD_EMIT         // present one buffered result
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    ptr_load;  // load the sweep pointer
      logic    ptr_sel;   // 0 from zero, 1 from scan offset / next string
      logic    ptr_step;  // advance the sweep pointer
      logic    out_clear; // clear the result buffer
   } ctrl_type;

   typedef struct packed {
      logic found;       // find-free hit or string search hit
      logic batch_full;  // batch holds BatchMax results
      logic has_results; // at least one result buffered
      logic pending;     // string pending
      logic emit_done;   // the last buffered result is the one just shown
      logic search_end;  // the string search has reached its bound or found a hit
   } stat_type;

   function automatic logic [2:0] pad_count(input logic [2:0] n);
      logic [2:0] r;
      case (n) inside
         3'd0: r = 3'd0;
         3'd1: r = 3'd1;
         3'd2: r = 3'd2;
         3'd3, 3'd4, 3'd5: r = 3'd5;
         default: r = 3'd7;
      endcase
      return r;
   endfunction

endpackage

[rtl/dirty_entry_update_scheduler.sv]
// Top level of the dirty entry update scheduler.
// Usage:
//   req_* carries one command word: tick, create, mark changed, set
//   visibility, delete or delete all. rsp_* returns the result words that
//   the command causes, rsp_tlast on the last word of each command.
//   A create returns one acknowledge; a tick returns either a graphic batch
//   of up to BATCH_MAX words or a single string word, or nothing.
// Timing:
//   Mark, visibility and delete are applied as the command is accepted.
//   Delete all walks the whole table; create walks it too and then shows
//   its acknowledge. A tick walks at most TABLE_DEPTH entries, one per
//   cycle, then does a string send and search; each word passes a load
//   state for the registered handle read before it shows. One command is
//   in work at a time; req_tready is low while it is.
// Reset:
//   reset clears all flags, the scan offset and string pending, and sets the
//   next handle to one. Handles hold garbage until their entry is created.
// Stall:
//   While rsp_tready is low the current word holds and the controller waits.
module dirty_entry_update_scheduler #(
   parameter int TABLE_DEPTH = deus_pkg::TableDepth,
   parameter int BATCH_MAX   = deus_pkg::BatchMax
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata fields from bit 0: func[2:0], entry_index[7:3], is_string[8],
   // visible_value[9], zero fill
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata fields from bit 0: kind[1:0], result_index[6:2], operation[8:7],
   // handle[32:9], table_full[33], padded_count[36:34], zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   deus_pkg::ctrl_type ctrl;
   deus_pkg::stat_type stat;
   logic busy, rsp_show, req_fire, rsp_fire;
   logic [1:0] o_kind, o_op;
   logic [4:0] o_idx;
   logic [23:0] o_handle;
   logic o_full, o_last;
   logic [2:0] o_pad;
   logic [AW:0] sweep_ff;
   logic str_ff;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_show;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // count sweep cycles for table walks
   always_ff @(posedge clock) begin
      if (reset) sweep_ff <= '0;
      else if (ctrl.ptr_load) sweep_ff <= '0;
      else if (ctrl.ptr_step) sweep_ff <= sweep_ff + 1'b1;
   end

   // hold is_string of the accepted word until the create writes the entry
   always_ff @(posedge clock) begin
      if (req_fire) str_ff <= req_tdata[8];
   end

   deus_controller #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .req_func(req_tdata[2:0]), .rsp_fire(rsp_fire), .stat(stat),
      .sweep_last(sweep_ff == (AW+1)'(TABLE_DEPTH - 1)),
      .ctrl(ctrl), .busy(busy), .rsp_show(rsp_show)
   );

   deus_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .BATCH_MAX(BATCH_MAX)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .cmd_func(req_tdata[2:0]), .cmd_index(req_tdata[7:3]),
      .cmd_is_string(str_ff), .cmd_visible(req_tdata[9]),
      .out_kind(o_kind), .out_index(o_idx), .out_operation(o_op),
      .out_handle(o_handle), .out_full(o_full), .out_pad(o_pad), .out_last(o_last)
   );

   assign rsp_tdata = {3'd0, o_pad, o_full, o_handle, o_op, o_idx, o_kind};
   assign rsp_tlast = o_last;

endmodule

[rtl/deus_datapath.sv]
// Datapath of the dirty entry update scheduler: entry table, scan pointer, result buffer.
module deus_datapath #(
   parameter int TABLE_DEPTH = deus_pkg::TableDepth,
   parameter int BATCH_MAX   = deus_pkg::BatchMax,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int BW = $clog2(BATCH_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  deus_pkg::ctrl_type ctrl,
   output deus_pkg::stat_type stat,
   input  logic [2:0]        cmd_func,
   input  logic [4:0]        cmd_index,
   input  logic              cmd_is_string,
   input  logic              cmd_visible,
   output logic [1:0]        out_kind,
   output logic [4:0]        out_index,
   output logic [1:0]        out_operation,
   output logic [23:0]       out_handle,
   output logic              out_full,
   output logic [2:0]        out_pad,
   output logic              out_last
);

   localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);

   deus_pkg::flags_type flags_ff [TABLE_DEPTH];
   logic [23:0] handle_mem [TABLE_DEPTH];

   logic [AW-1:0] scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic [23:0]   next_ff, next_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW:0]   left_ff, left_in;   // steps remaining in the sweep
   logic          found_ff, found_in;
   logic [AW-1:0] fidx_ff, fidx_in;

   // result buffer
   logic [AW-1:0] ridx_ff [BATCH_MAX];
   logic [1:0]    rop_ff [BATCH_MAX];
   logic [1:0]    rkind_ff, rkind_in;
   logic          rfull_ff, rfull_in;
   logic [BW-1:0] cnt_ff, cnt_in;
   logic [BW-1:0] rd_ff, rd_in;
   logic          wr_en;
   logic [AW-1:0] wr_idx;
   logic [1:0]    wr_op;

   logic [AW-1:0] hrd_addr;
   logic [23:0]   hrd_ff;

   deus_pkg::flags_type f_ptr, f_new, f_cmd, f_pend;
   logic          emit;
   logic [1:0]    emit_op;
   logic          cmd_ok;
   logic [AW-1:0] cmd_addr;
   logic [AW-1:0] ptr_next;
   logic [AW-1:0] pidx_next;

   assign cmd_addr = AW'(cmd_index);
   assign cmd_ok   = ({27'd0, cmd_index} < 32'(TABLE_DEPTH)) &&
                     flags_ff[cmd_addr][deus_pkg::FlagValid];
   assign f_ptr    = flags_ff[ptr_ff];
   assign f_cmd    = flags_ff[cmd_addr];
   assign f_pend   = flags_ff[pidx_ff];
   assign ptr_next = (ptr_ff == LastIdx) ? '0 : ptr_ff + 1'b1;
   assign pidx_next = (pidx_ff == LastIdx) ? '0 : pidx_ff + 1'b1;

   // scan step decision
   always_comb begin
      f_new   = f_ptr;
      emit    = 1'b0;
      emit_op = deus_pkg::OpAdd;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      if (ctrl.cmd == deus_pkg::CMD_SCAN && f_ptr[deus_pkg::FlagValid] &&
          (f_ptr[deus_pkg::FlagDirty] | f_ptr[deus_pkg::FlagDvis] |
           f_ptr[deus_pkg::FlagDel])) begin
         if (f_ptr[deus_pkg::FlagDel]) begin
            f_new[deus_pkg::FlagValid] = 1'b0;
            emit = 1'b1; emit_op = deus_pkg::OpDelete;
         end else if (f_ptr[deus_pkg::FlagDvis]) begin
            if (f_ptr[deus_pkg::FlagVis]) begin
               if (f_ptr[deus_pkg::FlagStr]) begin
                  if (!pend_ff) begin
                     pend_in = 1'b1; pidx_in = ptr_ff;
                  end
               end else begin
                  f_new[deus_pkg::FlagDvis] = 1'b0;
                  emit = 1'b1; emit_op = deus_pkg::OpAdd;
               end
            end else begin
               f_new[deus_pkg::FlagDvis] = 1'b0;
               emit = 1'b1; emit_op = deus_pkg::OpDelete;
            end
         end else if (f_ptr[deus_pkg::FlagStr] && !pend_ff) begin
            pend_in = 1'b1; pidx_in = ptr_ff;
         end else begin
            f_new[deus_pkg::FlagDirty] = 1'b0;
            emit = 1'b1; emit_op = deus_pkg::OpModify;
         end
      end
      if (ctrl.cmd == deus_pkg::CMD_STR_SEND) begin
         pend_in = 1'b0;
         pidx_in = pidx_next;
      end
      if (ctrl.cmd == deus_pkg::CMD_STR_SEARCH && !found_ff &&
          f_ptr[deus_pkg::FlagStr] &&
          (f_ptr[deus_pkg::FlagDirty] | f_ptr[deus_pkg::FlagDvis] |
           f_ptr[deus_pkg::FlagDel])) begin
         pend_in = 1'b1;
         pidx_in = ptr_ff;
      end
   end

   // pointer, sweep length, search hit
   always_comb begin
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      scan_in  = scan_ff;
      found_in = found_ff;
      fidx_in  = fidx_ff;
      next_in  = next_ff;
      if (ctrl.ptr_load) begin
         found_in = 1'b0;
         if (!ctrl.ptr_sel) begin
            ptr_in  = '0;
            left_in = (AW+1)'(TABLE_DEPTH);
         end else if (ctrl.cmd == deus_pkg::CMD_STR_SEND) begin
            // search from the entry after the pending one up to scan offset
            ptr_in  = pidx_next;
            left_in = (scan_ff <= pidx_next) ?
                      (AW+1)'(TABLE_DEPTH) - (AW+1)'(pidx_next) + (AW+1)'(scan_ff) :
                      (AW+1)'(scan_ff) - (AW+1)'(pidx_next);
         end else begin
            ptr_in  = scan_ff;
            left_in = (AW+1)'(TABLE_DEPTH);
         end
      end else if (ctrl.ptr_step) begin
         ptr_in  = ptr_next;
         left_in = left_ff - 1'b1;
      end
      if (ctrl.cmd == deus_pkg::CMD_SCAN) scan_in = ptr_next;
      if (ctrl.cmd == deus_pkg::CMD_FIND_FREE && !found_ff &&
          !f_ptr[deus_pkg::FlagValid]) begin
         found_in = 1'b1;
         fidx_in  = ptr_ff;
      end
      if (ctrl.cmd == deus_pkg::CMD_STR_SEARCH && !found_ff &&
          f_ptr[deus_pkg::FlagStr] &&
          (f_ptr[deus_pkg::FlagDirty] | f_ptr[deus_pkg::FlagDvis] |
           f_ptr[deus_pkg::FlagDel]))
         found_in = 1'b1;
      if (ctrl.cmd == deus_pkg::CMD_CREATE && found_ff) next_in = next_ff + 1'b1;
   end

   // result buffer write
   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = ptr_ff;
      wr_op    = emit_op;
      rkind_in = rkind_ff;
      rfull_in = rfull_ff;
      cnt_in   = cnt_ff;
      rd_in    = rd_ff;
      if (ctrl.out_clear) begin
         cnt_in = '0;
         rd_in  = '0;
      end
      unique case (ctrl.cmd)
         deus_pkg::CMD_SCAN: begin
            rkind_in = deus_pkg::KindBatch;
            rfull_in = 1'b0;
            if (emit) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         deus_pkg::CMD_CREATE: begin
            rkind_in = deus_pkg::KindAck;
            rfull_in = !found_ff;
            wr_en    = 1'b1;
            wr_idx   = found_ff ? fidx_ff : '0;
            wr_op    = deus_pkg::OpAdd;
            cnt_in   = BW'(1);
         end
         deus_pkg::CMD_STR_SEND: begin
            rkind_in = deus_pkg::KindString;
            rfull_in = 1'b0;
            wr_en    = 1'b1;
            wr_idx   = pidx_ff;
            wr_op    = (f_pend[deus_pkg::FlagDvis] && f_pend[deus_pkg::FlagVis]) ?
                       deus_pkg::OpAdd : deus_pkg::OpModify;
            cnt_in   = BW'(1);
         end
         deus_pkg::CMD_EMIT: rd_in = rd_ff + 1'b1;
         default: ;
      endcase
   end

   // flags table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) flags_ff[i] <= '0;
      end else begin
         unique case (ctrl.cmd)
            deus_pkg::CMD_FLAGS_CMD: begin
               if (cmd_ok) begin
                  unique case (cmd_func)
                     deus_pkg::FuncMark:
                        flags_ff[cmd_addr][deus_pkg::FlagDirty] <= 1'b1;
                     deus_pkg::FuncDelete:
                        flags_ff[cmd_addr][deus_pkg::FlagDel] <= 1'b1;
                     deus_pkg::FuncVisible:
                        if (f_cmd[deus_pkg::FlagVis] != cmd_visible) begin
                           flags_ff[cmd_addr][deus_pkg::FlagVis]  <= cmd_visible;
                           flags_ff[cmd_addr][deus_pkg::FlagDvis] <= 1'b1;
                        end
                     default: ;
                  endcase
               end
            end
            deus_pkg::CMD_DEL_ALL: flags_ff[ptr_ff][deus_pkg::FlagDel] <= 1'b1;
            deus_pkg::CMD_CREATE:
               if (found_ff)
                  flags_ff[fidx_ff] <= deus_pkg::flags_type'(
                     (1 << deus_pkg::FlagValid) | (1 << deus_pkg::FlagDvis) |
                     (1 << deus_pkg::FlagVis) |
                     (cmd_is_string ? (1 << deus_pkg::FlagStr) : 0));
            deus_pkg::CMD_SCAN: flags_ff[ptr_ff] <= f_new;
            deus_pkg::CMD_STR_SEND: begin
               flags_ff[pidx_ff][deus_pkg::FlagDirty] <= 1'b0;
               if (f_pend[deus_pkg::FlagDvis] && f_pend[deus_pkg::FlagVis])
                  flags_ff[pidx_ff][deus_pkg::FlagDvis] <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // handle memory: write on create, registered read for the result shown
   assign hrd_addr = ridx_ff[rd_in < BW'(BATCH_MAX) ? rd_in : '0];
   always_ff @(posedge clock) begin
      if (ctrl.cmd == deus_pkg::CMD_CREATE && found_ff) handle_mem[fidx_ff] <= next_ff;
      hrd_ff <= handle_mem[hrd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ridx_ff[(ctrl.cmd == deus_pkg::CMD_SCAN) ? cnt_ff : '0] <= wr_idx;
         rop_ff[(ctrl.cmd == deus_pkg::CMD_SCAN) ? cnt_ff : '0]  <= wr_op;
      end
      rkind_ff <= rkind_in;
      rfull_ff <= rfull_in;
      fidx_ff  <= fidx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         pend_ff  <= 1'b0;
         pidx_ff  <= '0;
         next_ff  <= 24'd1;
         ptr_ff   <= '0;
         left_ff  <= '0;
         found_ff <= 1'b0;
         cnt_ff   <= '0;
         rd_ff    <= '0;
      end else begin
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         pidx_ff  <= pidx_in;
         next_ff  <= next_in;
         ptr_ff   <= (ctrl.cmd == deus_pkg::CMD_STR_SEND && !ctrl.ptr_load) ?
                     pidx_ff : ptr_in;
         left_ff  <= left_in;
         found_ff <= found_in;
         cnt_ff   <= cnt_in;
         rd_ff    <= rd_in;
      end
   end

   logic [BW-1:0] rd_sel;
   assign rd_sel = (rd_ff < BW'(BATCH_MAX)) ? rd_ff : '0;

   assign out_kind      = rkind_ff;
   assign out_index     = rfull_ff ? 5'd0 : 5'(ridx_ff[rd_sel]);
   assign out_operation = rop_ff[rd_sel];
   assign out_handle    = rfull_ff ? 24'd0 : hrd_ff;
   assign out_full      = rfull_ff;
   assign out_pad       = (rkind_ff == deus_pkg::KindBatch) ?
                          deus_pkg::pad_count(3'(cnt_ff)) : 3'd0;
   assign out_last      = (rd_ff + 1'b1 == cnt_ff);

   assign stat.found       = found_ff;
   assign stat.batch_full  = (cnt_ff == BW'(BATCH_MAX));
   assign stat.has_results = (cnt_ff != '0);
   assign stat.pending     = pend_ff;
   assign stat.emit_done   = out_last;
   assign stat.search_end  = (left_ff == '0) || found_ff;

endmodule

[rtl/deus_controller.sv]
// Controller state machine of the dirty entry update scheduler.
module deus_controller #(
   parameter int TABLE_DEPTH = deus_pkg::TableDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [2:0]         req_func,
   input  logic               rsp_fire,
   input  deus_pkg::stat_type stat,
   input  logic               sweep_last,
   output deus_pkg::ctrl_type ctrl,
   output logic               busy,
   output logic               rsp_show
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DELALL  = 9'b000000010,
      ST_FIND    = 9'b000000100,
      ST_CREATE  = 9'b000001000,
      ST_SCAN    = 9'b000010000,
      ST_SEND    = 9'b000100000,
      ST_SEARCH  = 9'b001000000,
      ST_LOAD    = 9'b010000000,
      ST_OUT     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '{cmd: deus_pkg::CMD_NONE, default: 1'b0};
      rsp_show = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctrl.out_clear = 1'b1;
               case (req_func) inside
                  deus_pkg::FuncTick: begin
                     ctrl.ptr_load = 1'b1; ctrl.ptr_sel = 1'b1;
                     state_in = stat.pending ? ST_SEND : ST_SCAN;
                  end
                  deus_pkg::FuncCreate: begin
                     ctrl.ptr_load = 1'b1; state_in = ST_FIND;
                  end
                  deus_pkg::FuncDeleteAll: begin
                     ctrl.ptr_load = 1'b1; state_in = ST_DELALL;
                  end
                  deus_pkg::FuncMark, deus_pkg::FuncVisible, deus_pkg::FuncDelete:
                     ctrl.cmd = deus_pkg::CMD_FLAGS_CMD;
                  default: ;
               endcase
            end
         end
         ST_DELALL: begin
            ctrl.cmd = deus_pkg::CMD_DEL_ALL; ctrl.ptr_step = 1'b1;
            if (sweep_last) state_in = ST_IDLE;
         end
         ST_FIND: begin
            ctrl.cmd = deus_pkg::CMD_FIND_FREE; ctrl.ptr_step = 1'b1;
            if (sweep_last) state_in = ST_CREATE;
         end
         ST_CREATE: begin
            ctrl.cmd = deus_pkg::CMD_CREATE; state_in = ST_LOAD;
         end
         ST_SCAN: begin
            if (stat.batch_full || sweep_last && 1'b0) state_in = ST_LOAD;
            else begin
               ctrl.cmd = deus_pkg::CMD_SCAN; ctrl.ptr_step = 1'b1;
               if (sweep_last) state_in = ST_LOAD;
            end
            if (stat.batch_full) begin
               state_in = ST_LOAD;
            end
         end
         ST_SEND: begin
            // send the pending string and load the pointer for the search that follows
            ctrl.cmd = deus_pkg::CMD_STR_SEND; ctrl.ptr_load = 1'b1;
            ctrl.ptr_sel = 1'b1;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (stat.search_end) state_in = ST_LOAD;
            else begin
               ctrl.cmd = deus_pkg::CMD_STR_SEARCH; ctrl.ptr_step = 1'b1;
            end
         end
         ST_LOAD: begin
            // handle read settles; pick up a deferred string if the scan gave nothing
            if (!stat.has_results) begin
               if (stat.pending) state_in = ST_SEND;
               else state_in = ST_IDLE;
            end else state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_show = 1'b1;
            if (rsp_fire) begin
               ctrl.cmd = deus_pkg::CMD_EMIT;
               state_in = stat.emit_done ? ST_IDLE : ST_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[tb/tb_dirty_entry_update_scheduler.sv]
// Self-checking testbench for the dirty entry update scheduler.
`timescale 1ns / 1ps

module tb_dirty_entry_update_scheduler;

   localparam logic [2:0] FuncSpareLo = 3'd6;
   localparam logic [2:0] FuncSpareHi = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  index;
      logic [1:0]  op;
      logic [23:0] handle;
      logic        full;
      logic [2:0]  pad;
      logic        last;
   } word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   // model copy of the block state
   logic [5:0]  mdl_flags [deus_pkg::TableDepth];
   logic [23:0] mdl_handle [deus_pkg::TableDepth];
   logic [4:0]  mdl_scan;
   logic        mdl_pending;
   logic [4:0]  mdl_pend_idx;
   logic [23:0] mdl_next;

   word_type expected_words [$];
   int       errors;
   bit       rsp_stall_on;

   dirty_entry_update_scheduler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int gap_len();
      // mostly short gaps, now and then a long one
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic word_type make_word(logic [1:0] k, logic [4:0] i, logic [1:0] o,
                                          logic [23:0] h, logic f, logic [2:0] p,
                                          logic l);
      word_type w;
      w.kind = k; w.index = i; w.op = o; w.handle = h;
      w.full = f; w.pad = p; w.last = l;
      return w;
   endfunction

   // deferred string send: clear dirty, then hunt for the next pending string
   task automatic send_string_word();
      logic [4:0] p;
      logic [1:0] op;
      int         upper;
      int         e;
      p = mdl_pend_idx;
      op = deus_pkg::OpModify;
      mdl_flags[p][deus_pkg::FlagDirty] = 1'b0;
      if (mdl_flags[p][deus_pkg::FlagDvis] && mdl_flags[p][deus_pkg::FlagVis]) begin
         mdl_flags[p][deus_pkg::FlagDvis] = 1'b0;
         op = deus_pkg::OpAdd;
      end
      expected_words.push_back(make_word(deus_pkg::KindString, p, op, mdl_handle[p],
                                         1'b0, 3'd0, 1'b1));
      mdl_pend_idx = p + 5'd1;
      mdl_pending = 1'b0;
      upper = (mdl_scan <= mdl_pend_idx) ? mdl_scan + deus_pkg::TableDepth : mdl_scan;
      for (int i = mdl_pend_idx; i < upper; i++) begin
         e = i % deus_pkg::TableDepth;
         if ((mdl_flags[e][deus_pkg::FlagDirty] || mdl_flags[e][deus_pkg::FlagDvis] ||
              mdl_flags[e][deus_pkg::FlagDel]) && mdl_flags[e][deus_pkg::FlagStr]) begin
            mdl_pend_idx = e[4:0];
            mdl_pending = 1'b1;
            break;
         end
      end
   endtask

   task automatic predict_tick();
      logic [4:0] idx [deus_pkg::BatchMax];
      logic [1:0] ops [deus_pkg::BatchMax];
      int         count;
      int         start;
      int         e;
      int         emit;
      logic [5:0] f;
      count = 0;
      if (mdl_pending) begin
         send_string_word();
         return;
      end
      start = mdl_scan;
      for (int i = start; i < start + deus_pkg::TableDepth; i++) begin
         e = i % deus_pkg::TableDepth;
         f = mdl_flags[e];
         emit = -1;
         mdl_scan = mdl_scan + 5'd1;
         if (!f[deus_pkg::FlagValid]) continue;
         if (!(f[deus_pkg::FlagDirty] || f[deus_pkg::FlagDvis] || f[deus_pkg::FlagDel]))
            continue;
         if (f[deus_pkg::FlagDel]) begin
            f[deus_pkg::FlagValid] = 1'b0;
            emit = deus_pkg::OpDelete;
         end else if (f[deus_pkg::FlagDvis]) begin
            if (f[deus_pkg::FlagVis]) begin
               if (f[deus_pkg::FlagStr]) begin
                  if (!mdl_pending) begin
                     mdl_pending = 1'b1;
                     mdl_pend_idx = e[4:0];
                  end
               end else begin
                  f[deus_pkg::FlagDvis] = 1'b0;
                  emit = deus_pkg::OpAdd;
               end
            end else begin
               f[deus_pkg::FlagDvis] = 1'b0;
               emit = deus_pkg::OpDelete;
            end
         end else if (f[deus_pkg::FlagStr] && !mdl_pending) begin
            mdl_pending = 1'b1;
            mdl_pend_idx = e[4:0];
         end else begin
            f[deus_pkg::FlagDirty] = 1'b0;
            emit = deus_pkg::OpModify;
         end
         mdl_flags[e] = f;
         if (emit >= 0) begin
            idx[count] = e[4:0];
            ops[count] = emit[1:0];
            count++;
         end
         if (count >= deus_pkg::BatchMax) break;
      end
      if (count > 0) begin
         for (int k = 0; k < count; k++)
            expected_words.push_back(make_word(deus_pkg::KindBatch, idx[k], ops[k],
               mdl_handle[idx[k]], 1'b0, deus_pkg::pad_count(3'(count)), k == count - 1));
      end else if (mdl_pending) begin
         send_string_word();
      end
   endtask

   // advance the model by one command word and queue what it should return
   task automatic predict_command(logic [2:0] func, logic [4:0] e, logic str, logic vis);
      bit addressable;
      bit done;
      addressable = mdl_flags[e][deus_pkg::FlagValid];
      case (func)
         deus_pkg::FuncTick: predict_tick();
         deus_pkg::FuncCreate: begin
            done = 0;
            for (int i = 0; i < deus_pkg::TableDepth && !done; i++) begin
               if (!mdl_flags[i][deus_pkg::FlagValid]) begin
                  mdl_flags[i] = '0;
                  mdl_flags[i][deus_pkg::FlagValid] = 1'b1;
                  mdl_flags[i][deus_pkg::FlagDvis] = 1'b1;
                  mdl_flags[i][deus_pkg::FlagVis] = 1'b1;
                  mdl_flags[i][deus_pkg::FlagStr] = str;
                  mdl_handle[i] = mdl_next;
                  mdl_next = mdl_next + 24'd1;
                  expected_words.push_back(make_word(deus_pkg::KindAck, 5'(i),
                     deus_pkg::OpAdd, mdl_handle[i], 1'b0, 3'd0, 1'b1));
                  done = 1;
               end
            end
            if (!done)
               expected_words.push_back(make_word(deus_pkg::KindAck, 5'd0, deus_pkg::OpAdd,
                                                  24'd0, 1'b1, 3'd0, 1'b1));
         end
         deus_pkg::FuncMark: if (addressable) mdl_flags[e][deus_pkg::FlagDirty] = 1'b1;
         deus_pkg::FuncVisible: begin
            if (addressable && mdl_flags[e][deus_pkg::FlagVis] != vis) begin
               mdl_flags[e][deus_pkg::FlagVis] = vis;
               mdl_flags[e][deus_pkg::FlagDvis] = 1'b1;
            end
         end
         deus_pkg::FuncDelete: if (addressable) mdl_flags[e][deus_pkg::FlagDel] = 1'b1;
         deus_pkg::FuncDeleteAll:
            for (int i = 0; i < deus_pkg::TableDepth; i++)
               mdl_flags[i][deus_pkg::FlagDel] = 1'b1;
         default: ;
      endcase
   endtask

   // send one command word after a random gap and update the model on acceptance
   task automatic send_command(logic [2:0] func, logic [4:0] e, logic str, logic vis);
      int n;
      n = gap_len();
      @(negedge clock);
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tdata <= {6'd0, vis, str, e, func};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_command(func, e, str, vis);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // pick an index that is either created or harmless to address
   function automatic logic [4:0] pick_index();
      return 5'($urandom_range(0, deus_pkg::TableDepth - 1));
   endfunction

   task automatic test_directed();
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);      // empty table: nothing
      send_command(deus_pkg::FuncMark, 5'd31, 1'b0, 1'b0);     // invalid entry: ignored
      send_command(deus_pkg::FuncCreate, 5'd0, 1'b0, 1'b0);
      send_command(deus_pkg::FuncCreate, 5'd0, 1'b1, 1'b0);    // string entry
      send_command(deus_pkg::FuncCreate, 5'd0, 1'b0, 1'b0);
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);      // adds, string deferred
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);      // deferred string add
      send_command(deus_pkg::FuncMark, 5'd0, 1'b0, 1'b0);
      send_command(deus_pkg::FuncMark, 5'd1, 1'b0, 1'b0);
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);      // modify for entry 0, string deferred
      send_command(deus_pkg::FuncVisible, 5'd2, 1'b0, 1'b0);   // hide: delete op
      send_command(deus_pkg::FuncVisible, 5'd2, 1'b0, 1'b0);   // same value: no change
      send_command(deus_pkg::FuncVisible, 5'd1, 1'b0, 1'b0);   // hidden string: delete
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);
      send_command(deus_pkg::FuncDelete, 5'd1, 1'b0, 1'b1);
      send_command(FuncSpareLo, 5'd0, 1'b1, 1'b1);             // unused codes
      send_command(FuncSpareHi, 5'd31, 1'b1, 1'b1);
      send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_full_table();
      // fill past capacity to hit the full acknowledge, then sweep it all away
      for (int i = 0; i < deus_pkg::TableDepth + 2; i++)
         send_command(deus_pkg::FuncCreate, 5'd0, i[0], 1'b0);
      for (int i = 0; i < 7; i++) send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);
      send_command(deus_pkg::FuncDeleteAll, 5'd0, 1'b0, 1'b0);
      for (int i = 0; i < 7; i++) send_command(deus_pkg::FuncTick, 5'd0, 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_random(int n);
      int         r;
      logic [2:0] func;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) func = deus_pkg::FuncTick;
         else if (r < 45) func = deus_pkg::FuncCreate;
         else if (r < 63) func = deus_pkg::FuncMark;
         else if (r < 83) func = deus_pkg::FuncVisible;
         else if (r < 95) func = deus_pkg::FuncDelete;
         else if (r < 97) func = deus_pkg::FuncDeleteAll;
         else func = ($urandom_range(0, 1) == 0) ? FuncSpareLo : FuncSpareHi;
         send_command(func, pick_index(), 1'($urandom), 1'($urandom));
         if (i == n / 2) drain();   // hold off until every result is in
      end
      drain();
   endtask

   // receiver: random stalls, compare each word against the oldest expectation
   initial begin
      word_type got;
      word_type want;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !rsp_stall_on || (gap_len() == 0);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = make_word(rsp_tdata[1:0], rsp_tdata[6:2], rsp_tdata[8:7],
                            rsp_tdata[32:9], rsp_tdata[33], rsp_tdata[36:34], rsp_tlast);
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $realtime, got);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      errors = 0;
      rsp_stall_on = 1'b1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      for (int i = 0; i < deus_pkg::TableDepth; i++) begin
         mdl_flags[i] = '0;
         mdl_handle[i] = '0;
      end
      mdl_scan = '0;
      mdl_pending = 1'b0;
      mdl_pend_idx = '0;
      mdl_next = 24'd1;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_full_table();
      rsp_stall_on = 1'b0;       // a stretch with no receiver stalls
      test_random(40);
      rsp_stall_on = 1'b1;
      test_random(105);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
